// ----- sv/julian_date_to_calendar_assert.svh -----
// ----------------------------------------------------------------------------
// Julian date converter assertion macros
// Clocked checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JULIAN_DATE_TO_CALENDAR_ASSERT_SVH
`define JULIAN_DATE_TO_CALENDAR_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define JDC_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// When pre holds, post must hold at the same edge.
`define JDC_CHECK_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ----- sv/jdc_pkg.sv -----
// ----------------------------------------------------------------------------
// jdc_pkg
// Types and constants shared by the Julian date converter pipeline.
// ----------------------------------------------------------------------------
package jdc_pkg;

	localparam int FRACTION_BITS        = 32;
	localparam int SECOND_FRACTION_BITS = 20;
	localparam int JD_WHOLE_W           = 22;
	localparam int SEC_W                = SECOND_FRACTION_BITS + 6;
	localparam int YEAR_OUT_W           = 12;

	// Internal day arithmetic widths
	localparam int DAY_W  = 25;  // signed day counts
	localparam int A_W    = 26;  // signed biased dividend, fits unsigned in A_W-1
	localparam int Q_W    = 14;  // quotient of the 4-year division
	localparam int YR_W   = 15;  // signed year
	localparam int RECIP_W = 20;

	localparam logic signed [DAY_W-1:0] EPOCH_DAY      = 2415019;
	localparam logic signed [DAY_W-1:0] FIRST_YEAR     = 1900;
	localparam logic signed [DAY_W-1:0] LEAP_BASE_YEAR = 1901;
	localparam logic signed [DAY_W-1:0] YEAR_DAYS      = 365;
	localparam logic signed [DAY_W-1:0] DAY_ONE        = 1;

	// floor(4*temp/1461) = floor((4*temp + 1461*DIV_BIAS)/1461) - DIV_BIAS
	localparam int DIV_BIAS = 6700;
	localparam logic [A_W-2:0] DAYS_PER_4Y = 1461;
	localparam logic signed [A_W-1:0] DIV_OFFSET = A_W'(1461 * DIV_BIAS);
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP = 734936;  // floor(2^30 / 1461)
	localparam logic signed [YR_W-1:0] YEAR_BIAS = YR_W'(DIV_BIAS - 1900);

	localparam logic [SEC_W-1:0] SEC_LIMIT = SEC_W'(60) << SECOND_FRACTION_BITS;

	typedef struct packed {
		logic [JD_WHOLE_W-1:0]    jd_whole;
		logic [FRACTION_BITS-1:0] jd_fraction;
	} jdc_in_t;

	typedef struct packed {
		logic [YEAR_OUT_W-1:0] year;
		logic [3:0]            month;
		logic [4:0]            day;
		logic [4:0]            hour;
		logic [5:0]            minute;
		logic [SEC_W-1:0]      second_fixed;
	} jdc_out_t;

	// Per-stage advance strobes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} jdc_adv_t;

	// Days of the year before the first of month m
	function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		if (leap && m >= 4'd3) begin
			d = d + 9'd1;
		end
		return d;
	endfunction

endpackage

// ----- sv/jdc_date.sv -----
// ----------------------------------------------------------------------------
// jdc_date
// Date path: day count, year by 4-year division, rollback, month search.
// ----------------------------------------------------------------------------
module jdc_date (
	input  logic                             clk,
	input  jdc_pkg::jdc_adv_t                adv,
	input  jdc_pkg::jdc_in_t                 in_data,
	output logic [jdc_pkg::YEAR_OUT_W-1:0]   year,
	output logic [3:0]                       month,
	output logic [4:0]                       day
);
	import jdc_pkg::*;

	// stage 1: day offset, biased dividend
	logic signed [DAY_W-1:0] temp_c, n_c;
	logic signed [A_W-1:0]   a_c;
	logic signed [DAY_W-1:0] n_s1;
	logic [A_W-2:0]          a_s1;

	always_comb begin
		temp_c = $signed(DAY_W'(in_data.jd_whole)) - EPOCH_DAY;
		// half-day shift carries into the day iff the fraction's top bit is set
		n_c    = in_data.jd_fraction[FRACTION_BITS-1] ? temp_c : temp_c - DAY_ONE;
		a_c    = (A_W'(temp_c) <<< 2) + DIV_OFFSET;
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			n_s1 <= n_c;
			a_s1 <= a_c[A_W-2:0];
		end
	end

	// stage 2: reciprocal multiply, estimate may be one low
	localparam int PROD_W = A_W - 1 + RECIP_W;
	logic [PROD_W-1:0]       prod_c;
	logic [Q_W-1:0]          q0_s2;
	logic [A_W-2:0]          a_s2;
	logic signed [DAY_W-1:0] n_s2;

	assign prod_c = PROD_W'(a_s1) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			q0_s2 <= prod_c[RECIP_SHIFT +: Q_W];
			a_s2  <= a_s1;
			n_s2  <= n_s1;
		end
	end

	// stage 3: correct quotient, form year
	logic [A_W-2:0]          back_c, rem_c;
	logic [Q_W-1:0]          q_c;
	logic signed [YR_W-1:0]  year_s3;
	logic signed [DAY_W-1:0] n_s3;

	always_comb begin
		back_c = (A_W-1)'(q0_s2) * DAYS_PER_4Y;
		rem_c  = a_s2 - back_c;
		q_c    = q0_s2 + Q_W'(rem_c >= DAYS_PER_4Y);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			year_s3 <= $signed(YR_W'(q_c)) - YEAR_BIAS;
			n_s3    <= n_s2;
		end
	end

	// stage 4: day of year for this year and the one before
	logic signed [DAY_W-1:0] y_c, dy_c, base0_c, base1_c;
	logic signed [DAY_W-1:0] doy0_s4, doy1_s4;
	logic signed [YR_W-1:0]  year_s4;

	always_comb begin
		y_c     = DAY_W'(year_s3);
		dy_c    = y_c - FIRST_YEAR;
		base0_c = dy_c * YEAR_DAYS + ((y_c - LEAP_BASE_YEAR) >>> 2);
		base1_c = (dy_c - DAY_ONE) * YEAR_DAYS
			+ ((y_c - LEAP_BASE_YEAR - DAY_ONE) >>> 2);
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			doy0_s4 <= n_s3 - base0_c;
			doy1_s4 <= n_s3 - base1_c;
			year_s4 <= year_s3;
		end
	end

	// stage 5: roll back once, then find the month
	logic                    roll_c, leap_c;
	logic signed [DAY_W-1:0] doy_c;
	logic signed [YR_W-1:0]  ysel_c;
	logic [3:0]              month_c;
	logic [YEAR_OUT_W-1:0]   year_s5;
	logic [3:0]              month_s5;
	logic [4:0]              doy_lo_s5;
	logic                    leap_s5;

	always_comb begin
		roll_c  = doy0_s4 < DAY_ONE;
		doy_c   = roll_c ? doy1_s4 : doy0_s4;
		ysel_c  = roll_c ? year_s4 - YR_W'(1) : year_s4;
		leap_c  = ysel_c[1:0] == 2'b00;
		month_c = 4'd1;
		// month ends are increasing, so count the ones already passed
		for (int k = 1; k < 12; k++) begin
			if (doy_c > $signed(DAY_W'(days_before(4'(k + 1), leap_c)))) begin
				month_c = month_c + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			year_s5   <= ysel_c[YEAR_OUT_W-1:0];
			month_s5  <= month_c;
			doy_lo_s5 <= doy_c[4:0];
			leap_s5   <= leap_c;
		end
	end

	// stage 6: day of month
	logic [8:0] before_c;
	logic [YEAR_OUT_W-1:0] year_s6;
	logic [3:0]            month_s6;
	logic [4:0]            day_s6;

	assign before_c = days_before(month_s5, leap_s5);

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			year_s6  <= year_s5;
			month_s6 <= month_s5;
			day_s6   <= doy_lo_s5 - before_c[4:0];
		end
	end

	assign year  = year_s6;
	assign month = month_s6;
	assign day   = day_s6;

endmodule

// ----- sv/jdc_time.sv -----
// ----------------------------------------------------------------------------
// jdc_time
// Time path: split the day fraction into hour, minute and fixed-point seconds.
// ----------------------------------------------------------------------------
module jdc_time (
	input  logic                       clk,
	input  jdc_pkg::jdc_adv_t          adv,
	input  jdc_pkg::jdc_in_t           in_data,
	output logic [4:0]                 hour,
	output logic [5:0]                 minute,
	output logic [jdc_pkg::SEC_W-1:0]  second_fixed
);
	import jdc_pkg::*;

	localparam int FB    = FRACTION_BITS;
	localparam int EXT_W = FB + SEC_W;

	// stage 1: hours
	logic [FB-1:0]   f_c;
	logic [FB+4:0]   t1_c;
	logic [4:0]      hour_s1;
	logic [FB-1:0]   r1_s1;

	always_comb begin
		// adding half a day flips the top fraction bit
		f_c  = {~in_data.jd_fraction[FB-1], in_data.jd_fraction[FB-2:0]};
		t1_c = (FB+5)'(f_c) * (FB+5)'(24);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			hour_s1 <= t1_c[FB +: 5];
			r1_s1   <= t1_c[FB-1:0];
		end
	end

	// stage 2: minutes
	logic [FB+5:0] t2_c;
	logic [4:0]    hour_s2;
	logic [5:0]    minute_s2;
	logic [FB-1:0] r2_s2;

	assign t2_c = (FB+6)'(r1_s1) * (FB+6)'(60);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			hour_s2   <= hour_s1;
			minute_s2 <= t2_c[FB +: 6];
			r2_s2     <= t2_c[FB-1:0];
		end
	end

	// stage 3: seconds, rescaled to the output fraction width
	logic [FB+5:0]    t3_c;
	logic [EXT_W-1:0] ext_c;
	logic [4:0]       hour_s3, hour_s4, hour_s5, hour_s6;
	logic [5:0]       minute_s3, minute_s4, minute_s5, minute_s6;
	logic [SEC_W-1:0] sec_s3, sec_s4, sec_s5, sec_s6;

	always_comb begin
		t3_c  = (FB+6)'(r2_s2) * (FB+6)'(60);
		ext_c = EXT_W'(t3_c) << SECOND_FRACTION_BITS;
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			hour_s3   <= hour_s2;
			minute_s3 <= minute_s2;
			sec_s3    <= ext_c[FB +: SEC_W];
		end
	end

	// hold alongside the date path
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			hour_s4   <= hour_s3;
			minute_s4 <= minute_s3;
			sec_s4    <= sec_s3;
		end
		if (adv.s5) begin
			hour_s5   <= hour_s4;
			minute_s5 <= minute_s4;
			sec_s5    <= sec_s4;
		end
		if (adv.s6) begin
			hour_s6   <= hour_s5;
			minute_s6 <= minute_s5;
			sec_s6    <= sec_s5;
		end
	end

	assign hour         = hour_s6;
	assign minute       = minute_s6;
	assign second_fixed = sec_s6;

endmodule

// ----- sv/julian_date_to_calendar.sv -----
// ----------------------------------------------------------------------------
// julian_date_to_calendar
// Julian date to calendar date and universal time, six-stage pipeline.
//
//  channel | signals                      | word
//  --------+------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_data  | jd_whole, jd_fraction
//  output  | out_valid, out_ready, out_data | year .. second_fixed
//
// An accepted input word passes through stages s1 to s6 to the output;
// one word can enter every cycle unless the output stalls. The depth is
// set by the date path: reciprocal multiply, quotient fixup, year base,
// month search, day subtract. Reset clears only the stage valid bits.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output holds and bubbles behind it close up.
// ----------------------------------------------------------------------------
`include "julian_date_to_calendar_assert.svh"

module julian_date_to_calendar (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jdc_pkg::jdc_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output jdc_pkg::jdc_out_t  out_data
);
	import jdc_pkg::*;

	jdc_adv_t adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	always_comb begin
		adv.s6 = !valid_s6 || out_ready;
		adv.s5 = !valid_s5 || adv.s6;
		adv.s4 = !valid_s4 || adv.s5;
		adv.s3 = !valid_s3 || adv.s4;
		adv.s2 = !valid_s2 || adv.s3;
		adv.s1 = !valid_s1 || adv.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv.s1) valid_s1 <= in_valid;
			if (adv.s2) valid_s2 <= valid_s1;
			if (adv.s3) valid_s3 <= valid_s2;
			if (adv.s4) valid_s4 <= valid_s3;
			if (adv.s5) valid_s5 <= valid_s4;
			if (adv.s6) valid_s6 <= valid_s5;
		end
	end

	jdc_date u_date (
		.clk     (clk),
		.adv     (adv),
		.in_data (in_data),
		.year    (out_data.year),
		.month   (out_data.month),
		.day     (out_data.day)
	);

	jdc_time u_time (
		.clk          (clk),
		.adv          (adv),
		.in_data      (in_data),
		.hour         (out_data.hour),
		.minute       (out_data.minute),
		.second_fixed (out_data.second_fixed)
	);

	assign in_ready  = adv.s1;
	assign out_valid = valid_s6;

	`JDC_CHECK_IMPL(a_month_range, out_valid,
		out_data.month >= 4'd1 && out_data.month <= 4'd12, "month out of range")
	`JDC_CHECK_IMPL(a_hour_range, out_valid, out_data.hour <= 5'd23, "hour out of range")
	`JDC_CHECK_IMPL(a_minute_range, out_valid, out_data.minute <= 6'd59, "minute out of range")
	`JDC_CHECK_IMPL(a_second_range, out_valid, out_data.second_fixed < SEC_LIMIT,
		"seconds out of range")
	`JDC_CHECK(a_stall_holds_input, !(in_valid && !in_ready) || (valid_s1 && !adv.s2),
		"input refused while first stage could advance")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives Julian dates into julian_date_to_calendar and checks each returned
// calendar word against a behavioral converter kept in a small scoreboard.
// The run has three pacing phases: a slow receiver, then a slow sender, then
// both sides at full rate.
// ----------------------------------------------------------------------------
module testbench;
	import jdc_pkg::*;

	localparam int FB  = FRACTION_BITS;
	localparam int SFB = SECOND_FRACTION_BITS;
	localparam int SEC_RSH = (FB >= SFB) ? FB - SFB : 0;
	localparam int SEC_LSH = (SFB > FB) ? SFB - FB : 0;
	localparam longint unsigned FRAC_MASK = (64'd1 << FB) - 64'd1;

	localparam longint JD_EPOCH    = 2415019;
	localparam longint BASE_YEAR   = 1900;
	localparam longint LEAP_YEAR0  = 1901;
	localparam longint JD_LOW      = 2415020;
	localparam longint JD_HIGH     = 2488070;
	localparam longint JD_ALL_ONES = (64'd1 << JD_WHOLE_W) - 64'd1;

	// fraction that lands exactly on midnight after the half-day shift
	localparam logic [FB-1:0] MIDNIGHT = {1'b1, {(FB-1){1'b0}}};
	localparam logic [FB-1:0] LAST_TICK = MIDNIGHT - 1'b1;

	localparam int PHASE_WORDS  = 477;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 16;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	jdc_in_t   in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	jdc_out_t  out_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles  = 0;
	int words_sent    = 0;

	julian_date_to_calendar DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #10 clk = ~clk;

	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	// days before Jan 1 of the year, counted from the end of 1899
	function automatic longint year_start(input longint yr);
		return (yr - BASE_YEAR) * 365 + floor_div(yr - LEAP_YEAR0, 4);
	endfunction

	function automatic int month_len(input int m, input bit leap);
		case (m)
			2:            return leap ? 29 : 28;
			4, 6, 9, 11:  return 30;
			default:      return 31;
		endcase
	endfunction

	// whole day number whose midnight is day doy of the year
	function automatic longint day_jd(input longint yr, input longint doy);
		return JD_EPOCH + year_start(yr) + doy;
	endfunction

	function automatic jdc_in_t make_word(input longint whole, input logic [FB-1:0] frac);
		jdc_in_t w;
		w.jd_whole    = whole[JD_WHOLE_W-1:0];
		w.jd_fraction = frac;
		return w;
	endfunction

	class calendar_board;
		jdc_out_t calendar_q[$];
		int checked;
		int errors;

		function jdc_out_t to_calendar(jdc_in_t w);
			longint unsigned sum, f, t, hr, mn, r1, r2, sec;
			longint temp, days, yr, doy, acc;
			int m;
			bit leap;
			jdc_out_t r;
			sum = longint'(w.jd_fraction) + (64'd1 << (FB - 1));
			f = sum & FRAC_MASK;
			temp = longint'(w.jd_whole) - JD_EPOCH;
			// carry out of the half-day shift moves to the next day
			if (sum[FB]) begin
				days = temp;
			end else begin
				days = temp - 1;
			end
			yr = BASE_YEAR + floor_div(4 * temp, 1461);
			doy = days - year_start(yr);
			if (doy < 1) begin
				yr = yr - 1;
				doy = days - year_start(yr);
			end
			leap = (yr[1:0] == 2'b00);
			acc = 0;
			m = 1;
			while (m < 12 && doy > acc + month_len(m, leap)) begin
				acc = acc + month_len(m, leap);
				m++;
			end
			t   = f * 24;
			hr  = t >> FB;
			r1  = t & FRAC_MASK;
			t   = r1 * 60;
			mn  = t >> FB;
			r2  = t & FRAC_MASK;
			t   = r2 * 60;
			sec = (t >> SEC_RSH) << SEC_LSH;
			r.year         = yr[YEAR_OUT_W-1:0];
			r.month        = m[3:0];
			r.day          = 5'(doy - acc);
			r.hour         = hr[4:0];
			r.minute       = mn[5:0];
			r.second_fixed = sec[SEC_W-1:0];
			return r;
		endfunction

		function void note_date(jdc_in_t w);
			calendar_q.push_back(to_calendar(w));
		endfunction

		function void compare_field(string name, longint unsigned exp, longint unsigned act);
			if (exp != act) begin
				errors++;
				$error("%s: expected %0d, got %0d", name, exp, act);
			end
		endfunction

		function void check_result(jdc_out_t got);
			jdc_out_t exp;
			checked++;
			if (calendar_q.size() == 0) begin
				errors++;
				$error("calendar word arrived with no date outstanding");
				return;
			end
			exp = calendar_q.pop_front();
			compare_field("year",         exp.year,         got.year);
			compare_field("month",        exp.month,        got.month);
			compare_field("day",          exp.day,          got.day);
			compare_field("hour",         exp.hour,         got.hour);
			compare_field("minute",       exp.minute,       got.minute);
			compare_field("second_fixed", exp.second_fixed, got.second_fixed);
		endfunction
	endclass

	calendar_board board;

	// hold the word until accepted; idle cycles carry junk with valid low
	task automatic send_word(input jdc_in_t w);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid = 1'b0;
			in_data  = make_word(longint'($urandom), FB'($urandom));
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = w;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		board.note_date(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic run_directed();
		send_word(make_word(JD_LOW, '0));
		send_word(make_word(JD_HIGH, '1));
		send_word(make_word(0, '0));
		send_word(make_word(JD_ALL_ONES, '1));
		// 1900 comes out one day late
		send_word(make_word(day_jd(1900, 1), MIDNIGHT));
		send_word(make_word(day_jd(1900, 60), MIDNIGHT));
		send_word(make_word(day_jd(1900, 365), LAST_TICK));
		send_word(make_word(day_jd(1901, 1), MIDNIGHT));
		send_word(make_word(day_jd(1901, 0), LAST_TICK));
		// leap days and the day after
		send_word(make_word(day_jd(2000, 60), MIDNIGHT));
		send_word(make_word(day_jd(2000, 61), '0));
		send_word(make_word(day_jd(2096, 60), LAST_TICK));
		send_word(make_word(day_jd(1999, 59), MIDNIGHT));
		send_word(make_word(day_jd(2099, 365), LAST_TICK));
		// 2100 is taken as a leap year
		send_word(make_word(day_jd(2100, 60), MIDNIGHT));
		send_word(make_word(day_jd(2100, 366), MIDNIGHT));
		send_word(make_word(day_jd(2050, 0), MIDNIGHT));
		send_word(make_word(day_jd(2050, 1), '1));
		send_word(make_word(day_jd(2024, 335), MIDNIGHT));
		send_word(make_word(JD_HIGH + 1, MIDNIGHT));
	endtask

	task automatic run_random(input int count);
		int pick;
		int yr;
		longint whole;
		logic [FB-1:0] frac;
		repeat (count) begin
			pick = $urandom_range(99, 0);
			frac = FB'({$urandom, $urandom});
			if (pick < 65) begin
				whole = $urandom_range(JD_HIGH, JD_LOW);
			end else if (pick < 85) begin
				// straddle a year boundary, where the year estimate rolls back
				yr = $urandom_range(2100, 1900);
				whole = JD_EPOCH + year_start(yr) + $urandom_range(3, 0);
			end else if (pick < 93) begin
				whole = $urandom_range(JD_HIGH, JD_LOW);
				case ($urandom_range(3, 0))
					0:       frac = '0;
					1:       frac = '1;
					2:       frac = MIDNIGHT;
					default: frac = LAST_TICK;
				endcase
			end else begin
				whole = $urandom & JD_ALL_ONES;
			end
			send_word(make_word(whole, frac));
		end
	endtask

	always @(negedge clk) begin
		out_ready = ($urandom_range(99, 0) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_result(out_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		board = new();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 35;
		recv_idle_pct = 85;
		run_directed();
		run_random(PHASE_WORDS);

		send_idle_pct = 85;
		recv_idle_pct = 35;
		run_random(PHASE_WORDS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_WORDS);
		in_valid = 1'b0;

		while (board.calendar_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d dates sent, %0d calendar words checked, %0d mismatches",
			words_sent, board.checked, board.errors);
		$display("summary: ranges 1900-2100 plus out-of-range days, three pacing phases");
		if (board.errors == 0 && board.calendar_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
